>>> hw/rtl/mandelbrot_escape_time_unit_defines.svh
// assertion helpers shared by the escape time unit
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define MET_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/met_pkg.sv
package met_pkg;

  localparam int WORD_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int ITER_W     = 16;
  localparam int COORD_W    = 9;
  localparam int STEP_W     = 31;
  localparam int DIM_CFG_W  = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int MAX_DIM_DEF   = 512;
  localparam int FRAC_BITS_DEF = 27;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER   = 3'd0,
    REG_CENTER_RE  = 3'd1,
    REG_CENTER_IM  = 3'd2,
    REG_PIXEL_STEP = 3'd3,
    REG_IMG_WIDTH  = 3'd4,
    REG_IMG_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ITER_W-1:0]        max_iter;
    logic signed [WORD_W-1:0] center_re;
    logic signed [WORD_W-1:0] center_im;
    logic [STEP_W-1:0]        pixel_step;
  } cfg_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              in_set;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

>>> hw/rtl/mandelbrot_escape_time_unit.sv
// one pixel at a time: it is mapped to c in C_RE, C_IM and C_FIN, then each
//   iteration steps through SQ_RE, SQ_IM, CROSS, CHECK and UPD until escape
//   or max_iter; the one shared 32x32 multiplier serves the coordinate
//   products as well as re^2, im^2 and re*im
// reset: asynchronous active low, config and control registers return to their documented defaults
module mandelbrot_escape_time_unit #(
  parameter int MAX_DIM   = met_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [met_pkg::COORD_W-1:0]     col_i,
  input  logic [met_pkg::COORD_W-1:0]     row_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [met_pkg::ITER_W-1:0]      iter_count_o,
  output logic                            in_set_o,
  // register write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [met_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [met_pkg::WORD_W-1:0]      cfg_data_i
);
  import met_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  // default pitch spans two units across the full image
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'((64'd2 << FRAC_BITS) / MAX_DIM);
  // default view center at minus one half
  localparam logic [WORD_W-1:0] CRE_RST  = WORD_W'(-(64'sd1 <<< (FRAC_BITS - 1)));

  // image sizes above the supported maximum are treated as the maximum
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  cfg_t          cfg_q;
  logic [DW-1:0] width_q, height_q;

  core_stat_t    stat;
  res_t          res;

  logic          out_valid_q;
  res_t          out_q;
  logic          in_xfer, out_xfer, cfg_xfer, hold;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter   <= MAX_ITER_RST;
      cfg_q.center_re  <= CRE_RST;
      cfg_q.center_im  <= '0;
      cfg_q.pixel_step <= STEP_RST;
      width_q          <= DW'(MAX_DIM);
      height_q         <= DW'(MAX_DIM);
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data_i[ITER_W-1:0];
        REG_CENTER_RE:  cfg_q.center_re  <= cfg_data_i;
        REG_CENTER_IM:  cfg_q.center_im  <= cfg_data_i;
        REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data_i[STEP_W-1:0];
        REG_IMG_WIDTH:  width_q          <= clamp_dim(cfg_data_i[DIM_CFG_W-1:0]);
        REG_IMG_HEIGHT: height_q         <= clamp_dim(cfg_data_i[DIM_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  // a new pixel is taken whenever the sequencer is idle, even with a result
  // still parked in the output register
  assign in_stall_o = stat.busy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // the sequencer waits in its final step while the output register is full
  // and the result side is stalling
  assign hold = out_valid_q && out_stall_i;

  met_core #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .col_i    (col_i),
    .row_i    (row_i),
    .cfg_i    (cfg_q),
    .half_w_i (width_q >> 1),
    .half_h_i (height_q >> 1),
    .hold_i   (hold),
    .stat_o   (stat),
    .res_o    (res)
  );

  // output register: a new result may land in the same cycle the old one
  // transfers out
  assign out_xfer = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign iter_count_o = out_q.iter_count;
  assign in_set_o     = out_q.in_set;

endmodule

>>> hw/rtl/met_mul.sv
module met_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [met_pkg::WORD_W-1:0]   a_i,
  input  logic signed [met_pkg::WORD_W-1:0]   b_i,
  output logic signed [met_pkg::PROD_W-1:0]   p_o
);
  import met_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // registered signed product, held while not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/met_core.sv
`include "mandelbrot_escape_time_unit_defines.svh"

module met_core #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF,
  parameter int MAX_DIM   = met_pkg::MAX_DIM_DEF,
  localparam int DW       = $clog2(MAX_DIM + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [met_pkg::COORD_W-1:0]   col_i,
  input  logic [met_pkg::COORD_W-1:0]   row_i,
  input  met_pkg::cfg_t                 cfg_i,
  input  logic [DW-1:0]                 half_w_i,
  input  logic [DW-1:0]                 half_h_i,
  input  logic                          hold_i,
  output met_pkg::core_stat_t           stat_o,
  output met_pkg::res_t                 res_o
);
  import met_pkg::*;

  typedef enum logic [3:0] {
    IDLE, C_RE, C_IM, C_FIN, SQ_RE, SQ_IM, CROSS, CHECK, UPD, OUT
  } state_e;

  localparam logic [PROD_W-1:0] FOUR = PROD_W'(4) << (2 * FRAC_BITS);
  localparam logic signed [PROD_W-1:0] SMAX = PROD_W'(64'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SMIN = -PROD_W'(64'sh8000_0000);

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[WORD_W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  state_e state_q;
  res_t   res_q;

  logic [COORD_W-1:0]        col_q, row_q;
  logic signed [WORD_W-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic signed [PROD_W-1:0]  rr_q, ii_q, diff_q;
  logic [ITER_W-1:0]         cnt_q;

  logic                      mul_en;
  logic signed [WORD_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [WORD_W-1:0]  off_c, off_r, step_s;
  logic [PROD_W-1:0]         mag;
  logic                      escape;

  assign off_c  = $signed(WORD_W'(col_q)) - $signed(WORD_W'(half_w_i));
  assign off_r  = $signed(WORD_W'(row_q)) - $signed(WORD_W'(half_h_i));
  assign step_s = $signed({1'b0, cfg_i.pixel_step});

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = zr_q;
    mul_b  = zr_q;
    case (state_q)
      C_RE:    begin mul_a = off_c; mul_b = step_s; end
      C_IM:    begin mul_a = off_r; mul_b = step_s; end
      SQ_RE:   begin mul_a = zr_q;  mul_b = zr_q;   end
      SQ_IM:   begin mul_a = zi_q;  mul_b = zi_q;   end
      CROSS:   begin mul_a = zr_q;  mul_b = zi_q;   end
      default: mul_en = 1'b0;
    endcase
  end

  met_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign mag    = $unsigned(rr_q) + $unsigned(ii_q);
  assign escape = (cnt_q != '0) && (mag >= FOUR);

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      IDLE: begin
        if (start_i) begin
          col_q <= col_i;
          row_q <= row_i;
        end
      end
      C_IM:  cr_q <= sat_word(PROD_W'(cfg_i.center_re) + prod);
      C_FIN: begin
        ci_q  <= sat_word(PROD_W'(cfg_i.center_im) - prod);
        zr_q  <= '0;
        zi_q  <= '0;
        cnt_q <= '0;
      end
      SQ_IM: rr_q   <= prod;
      CROSS: ii_q   <= prod;
      CHECK: diff_q <= rr_q - ii_q;
      UPD: begin
        zr_q  <= sat_word((diff_q >>> FRAC_BITS) + PROD_W'(cr_q));
        zi_q  <= sat_word((prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_q));
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        IDLE:  if (start_i) state_q <= C_RE;
        C_RE:  state_q <= C_IM;
        C_IM:  state_q <= C_FIN;
        C_FIN: state_q <= SQ_RE;
        SQ_RE: state_q <= SQ_IM;
        SQ_IM: state_q <= CROSS;
        CROSS: state_q <= CHECK;
        CHECK: begin
          if (escape) begin
            res_q   <= '{iter_count: cnt_q - 1'b1, in_set: 1'b0};
            state_q <= OUT;
          end else if (cnt_q == cfg_i.max_iter) begin
            res_q   <= '{iter_count: cnt_q, in_set: 1'b1};
            state_q <= OUT;
          end else begin
            state_q <= UPD;
          end
        end
        UPD:   state_q <= SQ_RE;
        OUT:   if (!hold_i) state_q <= IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != IDLE);
  assign stat_o.done = (state_q == OUT) && !hold_i;
  assign res_o       = res_q;

  `MET_ASSERT(a_start_idle, start_i |-> state_q == IDLE, "start while busy")
  `MET_ASSERT(a_inset_limit, stat_o.done && res_q.in_set |-> res_q.iter_count == cfg_i.max_iter, "in_set without limit")
  `MET_ASSERT(a_escape_below, stat_o.done && !res_q.in_set |-> res_q.iter_count < cfg_i.max_iter, "escape index past limit")
  `MET_ASSERT(a_cnt_bound, state_q == UPD |-> cnt_q < cfg_i.max_iter, "iteration count overrun")
  `MET_ASSERT_RST(a_idle_no_done, state_q == IDLE |-> !stat_o.done, "result from idle")

endmodule
